@@ hdl/boot_eeprom_load_command_pager_defines.svh @@
// ----------------------------------------------------------------------------
// Boot EEPROM load-command pager: assertion macros
// Shared property shorthands for the pager's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BOOT_EEPROM_LOAD_COMMAND_PAGER_DEFINES_SVH
`define BOOT_EEPROM_LOAD_COMMAND_PAGER_DEFINES_SVH

// cond implies expr in the same cycle
`define BEP_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// cond implies expr in the next cycle
`define BEP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ hdl/bep_pkg.sv @@
// ----------------------------------------------------------------------------
// Boot EEPROM load-command pager: package
// Page geometry, command and byte codes, sequencer states, payload types.
// ----------------------------------------------------------------------------
package bep_pkg;

   localparam int PAGE_BYTES         = 32;
   localparam int EEPROM_TOTAL_BYTES = 8192;
   localparam int OFFSET_W           = $clog2(PAGE_BYTES);
   localparam int INDEX_W            = 9;
   localparam int ADDR_W             = 13;
   localparam int HDR_W              = 3;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [7:0] LOAD_BYTE = 8'h01;
   localparam logic [7:0] PAD_BYTE  = 8'h03;
   localparam logic [7:0] END_BYTE  = 8'h00;
   localparam logic [7:0] CHIP_ID   = 8'h00;

   localparam logic [HDR_W-1:0] HDR_LEN_HI  = 3'd1;
   localparam logic [HDR_W-1:0] HDR_LEN_LO  = 3'd2;
   localparam logic [HDR_W-1:0] HDR_CHIP    = 3'd3;
   localparam logic [HDR_W-1:0] HDR_ADDR_HI = 3'd4;
   localparam logic [HDR_W-1:0] HDR_ADDR_LO = 3'd5;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_HEADER,
      MODE_PAD,
      MODE_END
   } mode_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  start_page;
      logic [15:0] load_address;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] eeprom_address;
      logic [7:0]        byte_value;
      logic              page_complete;
      logic              overflow_error;
      logic              last;
   } rsp_type;

endpackage

@@ hdl/bep_if.sv @@
// ----------------------------------------------------------------------------
// Boot EEPROM load-command pager: channel interfaces
// Valid/ready request and response channels with packed payloads.
// ----------------------------------------------------------------------------
interface bep_req_if;
   import bep_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bep_rsp_if;
   import bep_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/boot_eeprom_load_command_pager.sv @@
// ----------------------------------------------------------------------------
// Boot EEPROM load-command pager
// Turns load commands into a paged boot EEPROM byte stream, one byte per
// response: header, payload bytes, 0x03 page padding and 0x00 end pages.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    cmd, start_page, load_address,
//                                    payload_length, data_byte
//   rsp_ch    out   valid / ready    eeprom_address, byte_value,
//                                    page_complete, overflow_error, last
//
// One-byte data requests leave the pager idle and stream back to back unless
// rsp_ch stalls. A start emits six header bytes, and pads to the page end if its
// payload is empty; a closing data request pads too; an end page is PAGE_BYTES
// bytes. Those bursts come from the byte sequencer, which holds req_ch.ready low.
// Reset is synchronous and leaves the pager idle at page 0 with no open command.
// A stalled response register holds its byte and blocks the next one.
// ----------------------------------------------------------------------------
`include "boot_eeprom_load_command_pager_defines.svh"

module boot_eeprom_load_command_pager (
   input logic       clock,
   input logic       reset,
   bep_req_if.sink   req_ch,
   bep_rsp_if.source rsp_ch
);
   import bep_pkg::*;

   mode_type            mode_ff, mode_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [15:0]         remain_ff, remain_in;
   logic                active_ff, active_in;
   logic [HDR_W-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]         clen_ff, clen_in;
   logic [15:0]         laddr_ff, laddr_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff, out_data_in;

   logic                load_ok;
   logic                req_ready;
   logic                accept;
   logic                cur_full;
   logic [OFFSET_W-1:0] cur_off_nx;
   logic [INDEX_W-1:0]  cur_idx_nx;
   logic                cur_ovf;
   logic                start_ovf;
   logic [INDEX_W-1:0]  start_idx;
   logic [15:0]         remain_dec;

   logic                emit;
   logic                e_ovf;
   logic                e_full;
   logic                e_last;
   logic [7:0]          e_byte;
   logic [7:0]          hdr_byte;
   logic [INDEX_W-1:0]  e_index;
   logic [OFFSET_W-1:0] e_offset;
   logic [31:0]         addr_wide;

   assign load_ok      = !out_valid_ff || rsp_ch.ready;
   assign req_ready    = (mode_ff == MODE_IDLE) && load_ok;
   assign req_ch.ready = req_ready;
   assign accept       = req_ch.valid && req_ready;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   assign start_idx  = INDEX_W'(req_ch.payload.start_page);
   assign cur_full   = (offset_ff == OFFSET_W'(PAGE_BYTES - 1));
   assign cur_off_nx = cur_full ? '0 : offset_ff + 1'b1;
   assign cur_idx_nx = cur_full ? index_ff + 1'b1 : index_ff;
   assign cur_ovf    = (32'(index_ff) * 32'(PAGE_BYTES)) >= 32'(EEPROM_TOTAL_BYTES);
   assign start_ovf  = (32'(start_idx) * 32'(PAGE_BYTES)) >= 32'(EEPROM_TOTAL_BYTES);
   assign remain_dec = remain_ff - 16'd1;

   always_comb begin
      case (hdr_cnt_ff)
         HDR_LEN_HI:  hdr_byte = clen_ff[15:8];
         HDR_LEN_LO:  hdr_byte = clen_ff[7:0];
         HDR_CHIP:    hdr_byte = CHIP_ID;
         HDR_ADDR_HI: hdr_byte = laddr_ff[15:8];
         default:     hdr_byte = laddr_ff[7:0];
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      index_in   = index_ff;
      offset_in  = offset_ff;
      remain_in  = remain_ff;
      active_in  = active_ff;
      hdr_cnt_in = hdr_cnt_ff;
      clen_in    = clen_ff;
      laddr_in   = laddr_ff;
      emit       = 1'b0;
      e_ovf      = 1'b0;
      e_full     = 1'b0;
      e_last     = 1'b0;
      e_byte     = END_BYTE;
      e_index    = index_ff;
      e_offset   = offset_ff;

      unique case (mode_ff)
         MODE_IDLE: begin
            if (accept) begin
               case (req_ch.payload.cmd)
                  CMD_START: begin
                     index_in   = start_idx;
                     offset_in  = '0;
                     hdr_cnt_in = HDR_LEN_HI;
                     clen_in    = req_ch.payload.payload_length + 16'd3;
                     laddr_in   = req_ch.payload.load_address;
                     emit       = 1'b1;
                     if (start_ovf) begin
                        e_ovf     = 1'b1;
                        e_last    = 1'b1;
                        active_in = 1'b0;
                        remain_in = '0;
                     end else begin
                        e_byte    = LOAD_BYTE;
                        e_index   = start_idx;
                        e_offset  = '0;
                        offset_in = OFFSET_W'(1);
                        active_in = 1'b1;
                        remain_in = req_ch.payload.payload_length;
                        mode_in   = MODE_HEADER;
                     end
                  end
                  CMD_DATA: begin
                     if (active_ff) begin
                        emit = 1'b1;
                        if (cur_ovf) begin
                           e_ovf     = 1'b1;
                           e_last    = 1'b1;
                           active_in = 1'b0;
                           remain_in = '0;
                           offset_in = '0;
                        end else begin
                           e_byte    = req_ch.payload.data_byte;
                           e_full    = cur_full;
                           offset_in = cur_off_nx;
                           index_in  = cur_idx_nx;
                           remain_in = remain_dec;
                           if (remain_dec == '0) begin
                              active_in = 1'b0;
                              if (cur_off_nx != '0) begin
                                 mode_in = MODE_PAD;
                              end else begin
                                 e_last = 1'b1;
                              end
                           end else begin
                              e_last = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_END: begin
                     active_in = 1'b0;
                     remain_in = '0;
                     offset_in = '0;
                     emit      = 1'b1;
                     if (cur_ovf) begin
                        e_ovf  = 1'b1;
                        e_last = 1'b1;
                     end else begin
                        e_byte    = END_BYTE;
                        e_offset  = '0;
                        offset_in = OFFSET_W'(1);
                        mode_in   = MODE_END;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         MODE_HEADER: begin
            if (load_ok) begin
               emit       = 1'b1;
               e_byte     = hdr_byte;
               e_full     = cur_full;
               offset_in  = cur_off_nx;
               index_in   = cur_idx_nx;
               hdr_cnt_in = hdr_cnt_ff + 1'b1;
               if (hdr_cnt_ff == HDR_ADDR_LO) begin
                  if (remain_ff == '0) begin
                     active_in = 1'b0;
                     if (cur_off_nx != '0) begin
                        mode_in = MODE_PAD;
                     end else begin
                        e_last  = 1'b1;
                        mode_in = MODE_IDLE;
                     end
                  end else begin
                     e_last  = 1'b1;
                     mode_in = MODE_IDLE;
                  end
               end
            end
         end
         MODE_PAD: begin
            if (load_ok) begin
               emit      = 1'b1;
               e_byte    = PAD_BYTE;
               e_full    = cur_full;
               offset_in = cur_off_nx;
               index_in  = cur_idx_nx;
               if (cur_full) begin
                  e_last  = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_END: begin
            if (load_ok) begin
               emit      = 1'b1;
               e_byte    = END_BYTE;
               e_full    = cur_full;
               offset_in = cur_off_nx;
               if (cur_full) begin
                  e_last  = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      addr_wide = 32'(e_index) * 32'(PAGE_BYTES) + 32'(e_offset);
   end

   always_comb begin
      out_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_data_in  = out_data_ff;
      if (emit) begin
         out_data_in.eeprom_address = e_ovf ? '0 : addr_wide[ADDR_W-1:0];
         out_data_in.byte_value     = e_ovf ? 8'h00 : e_byte;
         out_data_in.page_complete  = e_ovf ? 1'b0 : e_full;
         out_data_in.overflow_error = e_ovf;
         out_data_in.last           = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         index_ff     <= '0;
         offset_ff    <= '0;
         remain_ff    <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         index_ff     <= index_in;
         offset_ff    <= offset_in;
         remain_ff    <= remain_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_cnt_ff  <= hdr_cnt_in;
      clen_ff     <= clen_in;
      laddr_ff    <= laddr_in;
      out_data_ff <= out_data_in;
   end

   `BEP_ASSERT_IMPLY(a_burst_blocks_req, clock, reset, mode_ff != MODE_IDLE, !req_ch.ready, "request taken during a byte burst")
   `BEP_ASSERT_IMPLY(a_ovf_shape, clock, reset, rsp_ch.valid && rsp_ch.payload.overflow_error, rsp_ch.payload.last && !rsp_ch.payload.page_complete && (rsp_ch.payload.byte_value == 8'h00), "malformed overflow response")
   `BEP_ASSERT_NEXT(a_pad_ends_page, clock, reset, (mode_ff == MODE_PAD) && emit && cur_full, (mode_ff == MODE_IDLE) && (offset_ff == '0), "padding did not close the page")
   `BEP_ASSERT_IMPLY(a_active_in_header, clock, reset, mode_ff == MODE_HEADER, active_ff, "header burst without open command")

endmodule
